// File: rtl/imh_pkg.sv
package imh_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int MAX_INSERTS_DEF = 4096;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_SPARE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } status_t;

endpackage

// File: rtl/imh_ram.sv
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    // Contents are undefined until written.
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/indexed_min_heap.sv
// Channel | Signals                      | Payload
// --------+------------------------------+------------------------------
// in      | in_valid, in_ready           | action, value, ordinal
// out     | out_valid, out_ready         | status, min_value, size
//
// One item is handled at a time. A query or a full insert goes straight to
// the final state. An insert reads and compares once per level climbed; a
// delete looks up the slot by ordinal, then sifts the moved item down and
// percolates it up, one read at a time through the single read port of the
// slot memory. Reset (rst_n, asynchronous) empties the heap at once and needs
// no clearing pass. The result waits in an output register; a stalled output
// holds the block in its final state until the transfer.
module indexed_min_heap #(
    parameter int CAPACITY    = imh_pkg::CAPACITY_DEF,
    parameter int MAX_INSERTS = imh_pkg::MAX_INSERTS_DEF,
    parameter int VALUE_WIDTH = imh_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [31:0] value,
    input  logic [12:0]        ordinal,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] min_value,
    output logic [10:0]        size
);

    // Slot indexes run from 1 to CAPACITY; ordinals from 1 to MAX_INSERTS.
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int OW = $clog2(MAX_INSERTS + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int EW = VW + OW;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_UP_RD  = 10'b0000000010,
        S_UP_CMP = 10'b0000000100,
        S_DEL_P  = 10'b0000001000,
        S_DEL_S  = 10'b0000010000,
        S_DEL_L  = 10'b0000100000,
        S_DN_RL  = 10'b0001000000,
        S_DN_RR  = 10'b0010000000,
        S_DN_CMP = 10'b0100000000,
        S_FIN    = 10'b1000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [SW-1:0]   size_reg, size_next;
    logic [OW-1:0]   icnt_reg, icnt_next;
    logic [VW-1:0]   min_reg, min_next;
    logic [VW-1:0]   cur_val_reg, cur_val_next;
    logic [OW-1:0]   cur_ord_reg, cur_ord_next;
    logic [SW-1:0]   hole_reg, hole_next;
    logic [OW-1:0]   del_ord_reg, del_ord_next;
    logic [VW-1:0]   lval_reg, lval_next;
    logic [OW-1:0]   lord_reg, lord_next;
    logic            has_r_reg, has_r_next;
    logic [1:0]      stat_reg, stat_next;
    logic            out_valid_reg;
    logic [1:0]      out_stat_reg;
    logic [31:0]     out_min_reg;
    logic [10:0]     out_size_reg;

    // Slot memory holds {value, ordinal}; position memory maps ordinal to slot.
    logic            slot_we;
    logic [SW-1:0]   slot_waddr, slot_raddr;
    logic [EW-1:0]   slot_wdata, slot_rdata;
    logic            pos_we;
    logic [OW-1:0]   pos_waddr, pos_raddr;
    logic [SW-1:0]   pos_wdata, pos_rdata;

    imh_ram #(.WIDTH(EW), .DEPTH(CAPACITY + 1)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    imh_ram #(.WIDTH(SW), .DEPTH(MAX_INSERTS + 1)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    logic [31:0]   ord32;
    logic [31:0]   icnt32;
    logic [31:0]   size32;
    logic [63:0]   val64;
    logic [63:0]   min64;
    logic [VW-1:0] rd_val;
    logic [OW-1:0] rd_ord;
    logic [SW:0]   lchild;
    logic [SW:0]   rchild;
    logic [SW:0]   size_ext;
    logic          in_xfer;
    logic          out_free;

    assign ord32    = 32'(ordinal);
    assign icnt32   = 32'(icnt_reg);
    assign size32   = 32'(size_reg);
    assign val64    = 64'(value);
    assign min64    = 64'(min_reg);
    assign rd_val   = slot_rdata[EW-1:OW];
    assign rd_ord   = slot_rdata[OW-1:0];
    assign lchild   = {hole_reg, 1'b0};
    assign rchild   = lchild + (SW+1)'(1);
    assign size_ext = {1'b0, size_reg};
    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Every read targets the slot of the deleted item, a parent, a child or the
    // last slot of the heap, never the slot written in the same or the previous
    // cycle, so the memories need no forwarding.
    always_comb
    begin
        state_next   = state_reg;
        size_next    = size_reg;
        icnt_next    = icnt_reg;
        min_next     = min_reg;
        cur_val_next = cur_val_reg;
        cur_ord_next = cur_ord_reg;
        hole_next    = hole_reg;
        del_ord_next = del_ord_reg;
        lval_next    = lval_reg;
        lord_next    = lord_reg;
        has_r_next   = has_r_reg;
        stat_next    = stat_reg;
        slot_we      = 1'b0;
        slot_waddr   = hole_reg;
        slot_wdata   = {cur_val_reg, cur_ord_reg};
        slot_raddr   = hole_reg;
        pos_we       = 1'b0;
        pos_waddr    = cur_ord_reg;
        pos_wdata    = hole_reg;
        pos_raddr    = ord32[OW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    stat_next = imh_pkg::ST_OK;
                    case (imh_pkg::action_t'(action))
                        imh_pkg::ACT_INSERT:
                        begin
                            if (size32 >= 32'(CAPACITY) || icnt32 >= 32'(MAX_INSERTS))
                            begin
                                stat_next  = imh_pkg::ST_FULL;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                size_next    = size_reg + SW'(1);
                                icnt_next    = icnt_reg + OW'(1);
                                cur_val_next = val64[VW-1:0];
                                cur_ord_next = icnt_reg + OW'(1);
                                hole_next    = size_reg + SW'(1);
                                state_next   = S_UP_RD;
                            end
                        end
                        imh_pkg::ACT_DELETE:
                        begin
                            del_ord_next = ord32[OW-1:0];
                            if (ord32 == 32'd0 || ord32 > icnt32)
                            begin
                                stat_next  = imh_pkg::ST_BAD;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_DEL_P;
                            end
                        end
                        default:
                        begin
                            if (size_reg == '0)
                            begin
                                stat_next = imh_pkg::ST_EMPTY;
                            end
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_DEL_P:
            begin
                hole_next  = pos_rdata;
                slot_raddr = pos_rdata;
                if (pos_rdata == '0 || pos_rdata > size_reg)
                begin
                    stat_next  = imh_pkg::ST_BAD;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DEL_S;
                end
            end
            S_DEL_S:
            begin
                slot_raddr = size_reg;
                if (rd_ord != del_ord_reg)
                begin
                    stat_next  = imh_pkg::ST_BAD;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DEL_L;
                end
            end
            S_DEL_L:
            begin
                cur_val_next = rd_val;
                cur_ord_next = rd_ord;
                size_next    = size_reg - SW'(1);
                if (hole_reg == size_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DN_RL;
                end
            end
            S_DN_RL:
            begin
                slot_raddr = lchild[SW-1:0];
                if (lchild <= size_ext)
                begin
                    state_next = S_DN_RR;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end
            S_DN_RR:
            begin
                lval_next  = rd_val;
                lord_next  = rd_ord;
                slot_raddr = rchild[SW-1:0];
                has_r_next = (rchild <= size_ext);
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (has_r_reg && $signed(rd_val) < $signed(lval_reg)
                    && $signed(rd_val) < $signed(cur_val_reg))
                begin
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = rd_ord;
                    hole_next  = rchild[SW-1:0];
                    state_next = S_DN_RL;
                end
                else if ($signed(lval_reg) < $signed(cur_val_reg))
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {lval_reg, lord_reg};
                    pos_we     = 1'b1;
                    pos_waddr  = lord_reg;
                    hole_next  = lchild[SW-1:0];
                    state_next = S_DN_RL;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end
            S_UP_RD:
            begin
                slot_raddr = hole_reg >> 1;
                if (hole_reg > SW'(1))
                begin
                    state_next = S_UP_CMP;
                end
                else
                begin
                    slot_we    = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_UP_CMP:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                if ($signed(cur_val_reg) < $signed(rd_val))
                begin
                    slot_wdata = slot_rdata;
                    pos_waddr  = rd_ord;
                    hole_next  = hole_reg >> 1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The minimum is cached whenever the root slot is written.
        if (slot_we && slot_waddr == SW'(1))
        begin
            min_next = slot_wdata[EW-1:OW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            icnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            icnt_reg  <= icnt_next;
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg     <= min_next;
        cur_val_reg <= cur_val_next;
        cur_ord_reg <= cur_ord_next;
        hole_reg    <= hole_next;
        del_ord_reg <= del_ord_next;
        lval_reg    <= lval_next;
        lord_reg    <= lord_next;
        has_r_reg   <= has_r_next;
        stat_reg    <= stat_next;
        if (state_reg == S_FIN && out_free)
        begin
            out_stat_reg <= stat_reg;
            out_min_reg  <= (size_reg == '0) ? 32'd0 : min64[31:0];
            out_size_reg <= size32[10:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_stat_reg;
    assign min_value = out_min_reg;
    assign size      = out_size_reg;

`ifndef SYNTHESIS
    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        size32 <= 32'(CAPACITY))
        else $error("heap size above capacity");

    a_we_pair: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we == pos_we)
        else $error("slot and position writes out of step");

    a_size_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(size_reg) |-> ($past(state_reg) == S_IDLE || $past(state_reg) == S_DEL_L))
        else $error("size changed outside insert or delete");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |-> (slot_waddr != '0 && slot_waddr <= size_reg))
        else $error("slot write outside live heap");
`endif

endmodule
